FILE: rtl/pliu_pkg.sv
// ----------------------------------------------------------------------------
// pliu_pkg
// Shared widths, codes and sequencer states for the positional list unit.
// ----------------------------------------------------------------------------
package pliu_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 64;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CAPTURE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_DONE
  } seq_state_e;

endpackage

FILE: rtl/pliu_store.sv
// ----------------------------------------------------------------------------
// pliu_store
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pliu_store #(
  parameter int unsigned DEPTH      = pliu_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH      = pliu_pkg::DATA_WIDTH_DEF,
  parameter int unsigned ADDR_WIDTH = $clog2(pliu_pkg::CAPACITY_DEF)
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [ADDR_WIDTH-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]      wr_data_i,
  input  logic                  rd_en_i,
  input  logic [ADDR_WIDTH-1:0] rd_addr_i,
  output logic [WIDTH-1:0]      rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/positional_list_insert_erase_unit.sv
// ----------------------------------------------------------------------------
// positional_list_insert_erase_unit
// Ordered list of up to CAPACITY words: insert, erase or read at a position.
//
//   channel  dir  tdata (low bit up)                   tuser
//   s_axis   in   pos[4:0], data_in[68:5], zero pad    cmd[1:0]
//   m_axis   out  data_out[63:0], count[68:64], pad    status[1:0]
//
// After accept: a read fetches the entry at pos; an insert shifts the entries
// from pos up, then writes at pos; an erase fetches, then shifts down; a reject
// ends at once. The next request is taken in the cycle after the result is
// loaded. A move uses the single storage read port, then its write port.
// Reset clears the count and the sequencer; entry contents need no clearing.
// A finished result waits in the output register; a second one holds the
// sequencer until the receiver takes the first.
// ----------------------------------------------------------------------------
module positional_list_insert_erase_unit #(
  parameter int unsigned CAPACITY   = pliu_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = pliu_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos[4:0], data_in[68:5], zero [71:69]
  input  logic [pliu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // cmd[1:0]
  input  logic [pliu_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // data_out[63:0], count[68:64], zero [71:69]
  output logic [pliu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // status[1:0]
  output logic [pliu_pkg::STATUS_W-1:0]      m_axis_tuser
);

  localparam int unsigned IdxW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CmpW  = (IdxW > pliu_pkg::POS_W) ? IdxW : pliu_pkg::POS_W;

  pliu_pkg::seq_state_e state_q, state_d;

  logic [IdxW-1:0]       count_q, count_d;
  logic [IdxW-1:0]       idx_q;
  logic [IdxW-1:0]       limit_q;
  logic [IdxW-1:0]       pos_q;
  logic [IdxW-1:0]       idx_step;
  logic [DATA_WIDTH-1:0] word_q;
  logic [DATA_WIDTH-1:0] result_q;
  logic                  is_insert_q;
  logic                  is_erase_q;
  pliu_pkg::status_e     status_q;

  logic                          out_valid_q;
  logic [pliu_pkg::WORD_W-1:0]   out_data_q;
  logic [pliu_pkg::COUNT_W-1:0]  out_count_q;
  pliu_pkg::status_e             out_status_q;

  logic [pliu_pkg::POS_W-1:0] in_pos;
  pliu_pkg::cmd_e             in_cmd;
  logic                       in_insert;
  logic                       in_accept;
  pliu_pkg::status_e          in_status;

  logic                  rd_en, wr_en, out_load;
  logic [AddrW-1:0]      rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  assign in_pos    = s_axis_tdata[pliu_pkg::POS_W-1:0];
  assign in_cmd    = pliu_pkg::cmd_e'(s_axis_tuser);
  assign in_insert = (in_cmd == pliu_pkg::CMD_INSERT);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // admission check against the current count
  always_comb begin
    in_status = pliu_pkg::ST_OK;
    if (in_insert) begin
      if (count_q == IdxW'(CAPACITY)) begin
        in_status = pliu_pkg::ST_FULL;
      end else if (CmpW'(in_pos) > CmpW'(count_q)) begin
        in_status = pliu_pkg::ST_RANGE;
      end
    end else begin
      if (count_q == '0) begin
        in_status = pliu_pkg::ST_EMPTY;
      end else if (CmpW'(in_pos) >= CmpW'(count_q)) begin
        in_status = pliu_pkg::ST_RANGE;
      end
    end
  end

  // shared step unit: one index move per entry shifted
  assign idx_step = is_insert_q ? (idx_q - IdxW'(1)) : (idx_q + IdxW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pliu_pkg::S_IDLE: begin
        if (in_accept) begin
          if (in_status != pliu_pkg::ST_OK) begin
            state_d = pliu_pkg::S_DONE;
          end else if (in_insert) begin
            state_d = (count_q == IdxW'(in_pos)) ? pliu_pkg::S_PLACE : pliu_pkg::S_SHIFT_RD;
          end else begin
            state_d = pliu_pkg::S_FETCH;
          end
        end
      end
      pliu_pkg::S_FETCH:   state_d = pliu_pkg::S_CAPTURE;
      pliu_pkg::S_CAPTURE: begin
        state_d = (is_erase_q && (pos_q != limit_q)) ? pliu_pkg::S_SHIFT_RD
                                                     : pliu_pkg::S_DONE;
      end
      pliu_pkg::S_SHIFT_RD: state_d = pliu_pkg::S_SHIFT_WR;
      pliu_pkg::S_SHIFT_WR: begin
        if (idx_step == limit_q) begin
          state_d = is_insert_q ? pliu_pkg::S_PLACE : pliu_pkg::S_DONE;
        end else begin
          state_d = pliu_pkg::S_SHIFT_RD;
        end
      end
      pliu_pkg::S_PLACE: state_d = pliu_pkg::S_DONE;
      pliu_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = pliu_pkg::S_IDLE;
        end
      end
      default: state_d = pliu_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = pos_q[AddrW-1:0];
    wr_en         = 1'b0;
    wr_addr       = idx_q[AddrW-1:0];
    wr_data       = rd_data;
    out_load      = 1'b0;
    case (state_q)
      pliu_pkg::S_IDLE:  s_axis_tready = 1'b1;
      pliu_pkg::S_FETCH: rd_en = 1'b1;
      pliu_pkg::S_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_step[AddrW-1:0];
      end
      pliu_pkg::S_SHIFT_WR: wr_en = 1'b1;
      pliu_pkg::S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[AddrW-1:0];
        wr_data = word_q;
      end
      pliu_pkg::S_DONE: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (status_q == pliu_pkg::ST_OK) begin
      if (is_insert_q) begin
        count_d = count_q + IdxW'(1);
      end else if (is_erase_q) begin
        count_d = count_q - IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pliu_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      pliu_pkg::S_IDLE: begin
        if (in_accept) begin
          is_insert_q <= in_insert;
          is_erase_q  <= (in_cmd == pliu_pkg::CMD_ERASE);
          status_q    <= in_status;
          pos_q       <= IdxW'(in_pos);
          word_q      <= s_axis_tdata[pliu_pkg::POS_W +: DATA_WIDTH];
          result_q    <= '0;
          idx_q       <= count_q;
          limit_q     <= in_insert ? IdxW'(in_pos) : (count_q - IdxW'(1));
        end
      end
      pliu_pkg::S_CAPTURE: begin
        result_q <= rd_data;
        idx_q    <= pos_q;
      end
      pliu_pkg::S_SHIFT_WR: idx_q <= idx_step;
      default: ;
    endcase
    if (out_load) begin
      out_data_q   <= pliu_pkg::WORD_W'(result_q);
      out_count_q  <= pliu_pkg::COUNT_W'(count_d);
      out_status_q <= status_q;
    end
  end

  pliu_store #(
    .DEPTH      (CAPACITY),
    .WIDTH      (DATA_WIDTH),
    .ADDR_WIDTH (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(pliu_pkg::OUT_TDATA_W - pliu_pkg::WORD_W - pliu_pkg::COUNT_W){1'b0}},
                          out_count_q, out_data_q};
  assign m_axis_tuser  = out_status_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= IdxW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != pliu_pkg::S_IDLE)
    else $error("sequencer idle right after a request");

  a_count_only_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(count_q))
    else $error("count moved without a result");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_status_q != pliu_pkg::ST_OK)) |-> (out_data_q == '0))
    else $error("rejected request carries data");
`endif

endmodule
